@@ rtl/fnvh_pkg.sv @@
// Package for the FNV-1a hash map: status codes, hash constants, defaults.
// No dependencies.
package fnvh_pkg;
	localparam int TableDepthDef = 256;
	localparam int KeyBytesDef   = 8;
	localparam int ValueBitsDef  = 32;
	localparam logic [63:0] HASH_SEED = 64'hcbf29ce484222325;
	localparam logic [63:0] HASH_MULT = 64'h00000100000001b3;
	localparam logic [7:0]  FILL_RESET = 8'd128;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_UPDATED   = 3'd3;
	localparam logic [2:0] ST_NULL      = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic probe_rd;
		logic probe_next;
		logic wr_value;
		logic wr_insert;
		logic set_status;
		logic [2:0] status;
	} fnvh_cmd_t;

	typedef struct packed {
		logic hash_done;
		logic slot_free;
		logic key_match;
		logic probe_last;
		logic is_set;
		logic val_zero;
		logic below_limit;
	} fnvh_stat_t;
endpackage

@@ rtl/fnv1a_linear_probe_hash_map.sv @@
// FNV-1a 64 hash map with linear probing; top level of controller and datapath.
// Per item: each key byte is hashed by an xor/low-multiply step and a high-part sum step
// until a zero byte or KEY_BYTES bytes end the key; then each probe reads and checks a slot;
// a null set skips probing. One item at a time: the next input transfers in the cycle
// after the result transfer. Reset: arst_n clears all valid marks, the entry count and
// sets the fill limit to 128 at once. Depends on fnvh_pkg, fnvh_ctrl, fnvh_datapath.
module fnv1a_linear_probe_hash_map import fnvh_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDef,
	parameter int KEY_BYTES   = KeyBytesDef,
	parameter int VALUE_BITS  = ValueBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [63:0] key_text,
	input  logic [31:0] new_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] found_value,
	output logic [8:0]  entry_count,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data
);
	fnvh_cmd_t  cmd;
	fnvh_stat_t stat;

	fnvh_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
	);

	fnvh_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .stat, .action, .key_text, .new_value,
		.cfg_we, .cfg_data, .status, .found_value, .entry_count
	);
endmodule

@@ rtl/fnvh_datapath.sv @@
// Datapath: FNV-1a byte round with a split 64-bit multiply, table memories, counters.
// Depends on fnvh_pkg.
module fnvh_datapath import fnvh_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDef,
	parameter int KEY_BYTES   = KeyBytesDef,
	parameter int VALUE_BITS  = ValueBitsDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fnvh_cmd_t             cmd,
	output fnvh_stat_t            stat,
	input  logic                  action,
	input  logic [63:0]           key_text,
	input  logic [31:0]           new_value,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	output logic [2:0]            status,
	output logic [31:0]           found_value,
	output logic [8:0]            entry_count
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int BW = 4;
	localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [63:0]            key_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0]  val_mem [TABLE_DEPTH];
	logic [63:0]            rd_key_q;
	logic [VALUE_BITS-1:0]  rd_val_q;
	logic                   rd_valid_q;

	logic                   action_q;
	logic [63:0]            raw_q, norm_q, hash_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [BW-1:0]          byte_q;
	logic                   stop_q, phase_q;
	logic [63:0]            x_q, lo_q;
	logic [AW-1:0]          idx_q;
	logic [CW-1:0]          probes_q;
	logic [CW-1:0]          count_q;
	logic [7:0]             fill_q;
	logic [2:0]             status_q;
	logic [31:0]            found_q;

	logic [7:0]  cur_byte;
	logic [63:0] vfull;
	logic [63:0] xored;

	assign cur_byte = raw_q[{byte_q[2:0], 3'b000} +: 8];
	assign xored    = hash_q ^ {56'd0, cur_byte};
	assign vfull    = {32'd0, new_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			count_q  <= '0;
			fill_q   <= FILL_RESET;
			status_q <= ST_FOUND;
		end else begin
			if (cfg_we)
				fill_q <= cfg_data;
			if (cmd.wr_insert) begin
				valid_q[idx_q] <= 1'b1;
				count_q        <= count_q + CW'(1);
			end
			if (cmd.set_status)
				status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			raw_q    <= key_text;
			norm_q   <= '0;
			hash_q   <= HASH_SEED;
			val_q    <= vfull[VALUE_BITS-1:0];
			byte_q   <= '0;
			stop_q   <= 1'b0;
			phase_q  <= 1'b0;
		end else if (cmd.hash_step) begin
			if (!phase_q) begin
				if (cur_byte == 8'd0) begin
					stop_q <= 1'b1;
				end else begin
					x_q  <= xored;
					lo_q <= {32'd0, xored[31:0]} * {32'd0, HASH_MULT[31:0]};
					norm_q[{byte_q[2:0], 3'b000} +: 8] <= cur_byte;
					phase_q <= 1'b1;
				end
			end else begin
				hash_q  <= lo_q + {(x_q[63:32] * HASH_MULT[31:0])
					+ (x_q[31:0] * HASH_MULT[63:32]), 32'd0};
				byte_q  <= byte_q + BW'(1);
				phase_q <= 1'b0;
			end
		end
		if (cmd.probe_rd) begin
			rd_key_q   <= key_mem[idx_q];
			rd_val_q   <= val_mem[idx_q];
			rd_valid_q <= valid_q[idx_q];
		end
		if (cmd.wr_value || cmd.wr_insert)
			val_mem[idx_q] <= val_q;
		if (cmd.wr_insert)
			key_mem[idx_q] <= norm_q;
		if (stat.hash_done && !cmd.probe_next && !cmd.probe_rd && !cmd.set_status) begin
			idx_q    <= hash_q[AW-1:0];
			probes_q <= '0;
		end else if (cmd.probe_next) begin
			idx_q    <= (idx_q == AW'(TABLE_DEPTH - 1)) ? '0 : idx_q + AW'(1);
			probes_q <= probes_q + CW'(1);
		end
		if (cmd.set_status)
			found_q <= (cmd.status == ST_FOUND) ? 32'(rd_val_q[VW-1:0]) : 32'd0;
	end

	assign stat.hash_done   = stop_q || (byte_q == BW'(KEY_BYTES));
	assign stat.slot_free   = !rd_valid_q;
	assign stat.key_match   = rd_key_q == norm_q;
	assign stat.probe_last  = probes_q == CW'(TABLE_DEPTH - 1);
	assign stat.is_set      = action_q;
	assign stat.val_zero    = val_q == '0;
	assign stat.below_limit = 32'(count_q) < 32'(fill_q);

	assign status      = status_q;
	assign found_value = found_q;
	assign entry_count = 9'(count_q);
endmodule

@@ rtl/fnvh_ctrl.sv @@
// Controller: sequences hash rounds, probe reads and table writes per item.
// Depends on fnvh_pkg.
module fnvh_ctrl import fnvh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  fnvh_stat_t stat,
	output fnvh_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q, state_d;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				if (stat.hash_done) begin
					if (stat.is_set && stat.val_zero) begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_NULL;
						state_d        = S_OUT;
					end else begin
						state_d = S_RD;
					end
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			S_RD: begin
				cmd.probe_rd = 1'b1;
				state_d      = S_CHK;
			end
			S_CHK: begin
				cmd.set_status = 1'b1;
				state_d        = S_OUT;
				if (stat.slot_free) begin
					if (!stat.is_set) begin
						cmd.status = ST_NOT_FOUND;
					end else if (stat.below_limit) begin
						cmd.status    = ST_INSERTED;
						cmd.wr_insert = 1'b1;
					end else begin
						cmd.status = ST_FULL;
					end
				end else if (stat.key_match) begin
					cmd.status   = stat.is_set ? ST_UPDATED : ST_FOUND;
					cmd.wr_value = stat.is_set;
				end else if (stat.probe_last) begin
					cmd.status = stat.is_set ? ST_FULL : ST_NOT_FOUND;
				end else begin
					cmd.set_status = 1'b0;
					cmd.probe_next = 1'b1;
					state_d        = S_RD;
				end
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
